>>> hw/rtl/mrs_pkg.sv
// Shared types and codes for the move-to-front rotation selector.
package mrs_pkg;

	// Action codes.
	localparam logic [1:0] ACT_CLEAR  = 2'd0;
	localparam logic [1:0] ACT_APPEND = 2'd1;
	localparam logic [1:0] ACT_USE    = 2'd2;
	localparam logic [1:0] ACT_QUERY  = 2'd3;

	// Status codes.
	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
	localparam logic [1:0] STAT_FULL      = 2'd2;

	typedef struct packed {
		logic [1:0]         action;
		logic [7:0]         group_id;
		logic signed [15:0] subtype_id;
		logic               aware;
		logic               same_group_only;
	} req_t;

	typedef struct packed {
		logic               found;
		logic [7:0]         next_group;
		logic signed [15:0] next_subtype;
		logic [3:0]         next_slot;
		logic [1:0]         status;
	} rsp_t;

	// Entry data that travels with a ring cell.
	typedef struct packed {
		logic [7:0]         group;
		logic signed [15:0] subtype;
		logic               aware;
	} ent_t;

	// Controls shared by every ring cell.
	typedef struct packed {
		logic shift;
		logic init;
	} cell_ctl_t;

endpackage

>>> hw/rtl/mrs_cell.sv
// One ring cell: a usage-order position holding a table slot and its entry.
module mrs_cell import mrs_pkg::*; #(
	parameter int            SW  = 4,
	parameter logic [SW-1:0] IDX = '0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cell_ctl_t     ctl,
	input  logic          wr_en,
	input  ent_t          wr_ent,
	input  logic [SW-1:0] nbr_slot,
	input  ent_t          nbr_ent,
	output logic [SW-1:0] slot,
	output ent_t          ent
);

	logic [SW-1:0] slot_q;
	ent_t          ent_q;

	// Slot index resets to identity.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= IDX;
		end else if (ctl.init) begin
			slot_q <= IDX;
		end else if (ctl.shift) begin
			slot_q <= nbr_slot;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			ent_q <= nbr_ent;
		end else if (wr_en) begin
			ent_q <= wr_ent;
		end
	end

	assign slot = slot_q;
	assign ent  = ent_q;

endmodule

>>> hw/rtl/mru_rotation_next_selector.sv
// Top level: move-to-front rotation selector built on a rotating ring of cells.
//
//  channel | direction | handshake            | beat
//  --------+-----------+----------------------+---------------------------------
//  req     | in        | req_valid/req_stall  | action, group, subtype, flags
//  rsp     | out       | rsp_valid/rsp_stall  | found, next group/subtype/slot, status
//
// Steps: clear, append and an unaware use event go from idle straight to finish.
// An aware use event or a next query makes one full ring rotation to locate
// the current entry, a second rotation to scan candidates (query) or to shift
// the entry to the front (use), then the finish step.
// When the current entry is missing the second rotation is skipped.
// Reset: async, active low; table empty, usage order identity.
// Stalls: rsp is registered, so a new req beat is taken while a result waits;
// only a finished item that finds rsp still occupied waits in the finish state.
module mru_rotation_next_selector import mrs_pkg::*; #(
	parameter int ENTRIES = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int SW  = $clog2(ENTRIES);
	localparam int CW  = $clog2(ENTRIES + 1);
	localparam int SXW = (SW > 4) ? SW : 4;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOCATE,
		S_NEXT,
		S_MOVE,
		S_FINISH
	} state_t;

	state_t        state_q;
	req_t          req_q;
	logic [CW-1:0] count_q;
	logic [SW-1:0] k_q;       // ring position currently at the head
	logic          hit_q;
	logic [SW-1:0] pos_q;     // walk key of the current entry
	logic [SW-1:0] carry_slot_q;
	ent_t          carry_ent_q;
	logic          best_q;
	logic [SW-1:0] bdist_q;
	logic [SW-1:0] bslot_q;
	ent_t          bent_q;
	logic [1:0]    status_q;
	logic          rsp_valid_q;
	rsp_t          rsp_q;

	// Ring wiring: cell 0 is the head; cell ENTRIES-1 takes the pushed value.
	logic [SW-1:0]      slot_w [ENTRIES];
	ent_t               ent_w  [ENTRIES];
	logic [ENTRIES-1:0] wr_en_w;
	logic [SW-1:0]      push_slot;
	ent_t               push_ent;
	cell_ctl_t          ctl;
	ent_t               wr_ent;

	logic          accept;
	logic          app_ok;
	logic          last;
	logic          in_list;
	logic [SW-1:0] key;
	logic          loc_match;
	logic          loc_take;
	logic          cand;
	logic [CW:0]   dsum;
	logic [SW-1:0] gap;
	logic          nxt_take;
	logic [SXW-1:0] slot_x;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && (state_q == S_IDLE);
	assign app_ok    = accept && (req.action == ACT_APPEND) && (count_q < CW'(ENTRIES));
	assign last      = (k_q == SW'(ENTRIES - 1));

	assign ctl.shift = (state_q == S_LOCATE) || (state_q == S_NEXT) || (state_q == S_MOVE);
	assign ctl.init  = accept && (req.action == ACT_CLEAR);
	assign wr_ent    = '{group: req.group_id, subtype: req.subtype_id, aware: req.aware};

	// Head cell evaluation. Aware walk is keyed by usage position, unaware by slot.
	assign in_list   = (CW'(k_q) < count_q);
	assign key       = req_q.aware ? k_q : slot_w[0];
	assign loc_match = in_list && (ent_w[0].group == req_q.group_id) &&
		(ent_w[0].subtype == req_q.subtype_id) && (ent_w[0].aware == req_q.aware);
	assign loc_take  = loc_match && (!hit_q || (key < pos_q));

	assign cand = in_list && (ent_w[0].aware == req_q.aware) &&
		(!req_q.same_group_only || (ent_w[0].group == req_q.group_id)) && (key != pos_q);

	// Cyclic distance from the current entry, modulo the fill count.
	always_comb begin
		if (key > pos_q) begin
			dsum = (CW + 1)'(key) - (CW + 1)'(pos_q);
		end else begin
			dsum = (CW + 1)'(key) + {1'b0, count_q} - (CW + 1)'(pos_q);
		end
	end
	assign gap      = dsum[SW-1:0];
	assign nxt_take = cand && (!best_q || (gap < bdist_q));

	// Pushed value: unchanged head, except during the front shift.
	always_comb begin
		push_slot = slot_w[0];
		push_ent  = ent_w[0];
		if ((state_q == S_MOVE) && (k_q <= pos_q)) begin
			push_slot = carry_slot_q;
			push_ent  = carry_ent_q;
		end
	end

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		assign wr_en_w[i] = app_ok && (count_q == CW'(i));
		if (i == ENTRIES - 1) begin : g_tail
			mrs_cell #(.SW(SW), .IDX(SW'(i))) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctl      (ctl),
				.wr_en    (wr_en_w[i]),
				.wr_ent   (wr_ent),
				.nbr_slot (push_slot),
				.nbr_ent  (push_ent),
				.slot     (slot_w[i]),
				.ent      (ent_w[i])
			);
		end else begin : g_body
			mrs_cell #(.SW(SW), .IDX(SW'(i))) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctl      (ctl),
				.wr_en    (wr_en_w[i]),
				.wr_ent   (wr_ent),
				.nbr_slot (slot_w[i+1]),
				.nbr_ent  (ent_w[i+1]),
				.slot     (slot_w[i]),
				.ent      (ent_w[i])
			);
		end
	end

	assign slot_x = SXW'(bslot_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			req_q        <= '0;
			count_q      <= '0;
			k_q          <= '0;
			hit_q        <= 1'b0;
			pos_q        <= '0;
			carry_slot_q <= '0;
			carry_ent_q  <= '0;
			best_q       <= 1'b0;
			bdist_q      <= '0;
			bslot_q      <= '0;
			bent_q       <= '0;
			status_q     <= STAT_OK;
			rsp_valid_q  <= 1'b0;
			rsp_q        <= '0;
		end else begin
			// finish cycle owns rsp_valid_q while it is active
			if (rsp_valid_q && !rsp_stall && (state_q != S_FINISH)) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						req_q    <= req;
						k_q      <= '0;
						hit_q    <= 1'b0;
						best_q   <= 1'b0;
						case (req.action)
							ACT_CLEAR: begin
								count_q  <= '0;
								status_q <= STAT_OK;
								state_q  <= S_FINISH;
							end
							ACT_APPEND: begin
								if (count_q < CW'(ENTRIES)) begin
									count_q  <= count_q + 1'b1;
									status_q <= STAT_OK;
								end else begin
									status_q <= STAT_FULL;
								end
								state_q <= S_FINISH;
							end
							ACT_USE: begin
								// Unaware use events are ignored.
								status_q <= STAT_OK;
								state_q  <= req.aware ? S_LOCATE : S_FINISH;
							end
							default: begin
								status_q <= STAT_OK;
								state_q  <= S_LOCATE;
							end
						endcase
					end
				end
				S_LOCATE: begin
					k_q <= last ? '0 : k_q + 1'b1;
					if (loc_take) begin
						hit_q        <= 1'b1;
						pos_q        <= key;
						carry_slot_q <= slot_w[0];
						carry_ent_q  <= ent_w[0];
					end
					if (last) begin
						if (!(hit_q || loc_take)) begin
							status_q <= STAT_NOT_FOUND;
							state_q  <= S_FINISH;
						end else if (req_q.action == ACT_USE) begin
							state_q <= S_MOVE;
						end else begin
							state_q <= S_NEXT;
						end
					end
				end
				S_NEXT: begin
					k_q <= last ? '0 : k_q + 1'b1;
					if (nxt_take) begin
						best_q  <= 1'b1;
						bdist_q <= gap;
						bslot_q <= slot_w[0];
						bent_q  <= ent_w[0];
					end
					if (last) begin
						state_q <= S_FINISH;
					end
				end
				S_MOVE: begin
					// Carry bubbles positions up to the moved one down by one.
					k_q <= last ? '0 : k_q + 1'b1;
					if (k_q <= pos_q) begin
						carry_slot_q <= slot_w[0];
						carry_ent_q  <= ent_w[0];
					end
					if (last) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_valid_q        <= 1'b1;
						rsp_q.found        <= best_q;
						rsp_q.next_group   <= best_q ? bent_q.group : 8'd0;
						rsp_q.next_subtype <= best_q ? bent_q.subtype : 16'sd0;
						rsp_q.next_slot    <= best_q ? slot_x[3:0] : 4'd0;
						rsp_q.status       <= status_q;
						state_q            <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Fill count never passes the table depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(ENTRIES))
		else $error("entry count above table depth");

	// Every pass ends with the ring back in alignment.
	a_ring_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE || state_q == S_FINISH) |-> (k_q == '0))
		else $error("ring left misaligned after a pass");

	// An append with room grows the table by one.
	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.action == ACT_APPEND && count_q < CW'(ENTRIES))
		|=> (count_q == $past(count_q) + 1'b1))
		else $error("append did not grow table");

	// A selected entry always comes with an ok status.
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.found) |-> (rsp.status == STAT_OK))
		else $error("found result with error status");

endmodule
